// ----- hdl/tam_pkg.sv -----
// Shared types and constants for the tiny accumulator machine.
`timescale 1ns / 1ps

package tam_pkg;

    // Opcode encodings.
    localparam logic [7:0] OP_LOAD  = 8'd1;
    localparam logic [7:0] OP_ADD   = 8'd2;
    localparam logic [7:0] OP_STORE = 8'd3;
    localparam logic [7:0] OP_SUB   = 8'd4;
    localparam logic [7:0] OP_IN    = 8'd5;
    localparam logic [7:0] OP_OUT   = 8'd6;
    localparam logic [7:0] OP_END   = 8'd7;
    localparam logic [7:0] OP_JMP   = 8'd8;
    localparam logic [7:0] OP_SKIPZ = 8'd9;

    // Fixed field geometry.
    localparam int WORD_W     = 8;
    localparam int ACC_W      = 32;
    localparam int SLOT_W     = 7;
    localparam int LOAD_SLOTS = 128;
    localparam int ARG_VALUES = 256;
    localparam int PC_OUT_W   = 8;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_HALT   = 2'd1,
        ST_FAULT  = 2'd2,
        ST_LOADED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_FETCH,
        S_EXEC,
        S_HALT
    } t_state;

endpackage

// ----- hdl/tam_req_if.sv -----
// Request channel of the tiny accumulator machine: load or step beats.
`timescale 1ns / 1ps

interface tam_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [6:0]         load_index;
    logic [7:0]         opcode_word;
    logic [7:0]         operand_word;
    logic signed [31:0] in_value;

    modport source (
        output valid, req_type, load_index, opcode_word, operand_word, in_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, load_index, opcode_word, operand_word, in_value,
        output ready
    );
endinterface

// ----- hdl/tam_rsp_if.sv -----
// Result channel of the tiny accumulator machine.
`timescale 1ns / 1ps

interface tam_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [7:0]         pc;
    logic signed [31:0] acc;
    logic               out_valid;
    logic [7:0]         exec_opcode;

    modport source (
        output valid, status, pc, acc, out_valid, exec_opcode,
        input  ready
    );
    modport sink (
        input  valid, status, pc, acc, out_valid, exec_opcode,
        output ready
    );
endinterface

// ----- hdl/tiny_accumulator_machine_core.sv -----
// Top level of the tiny accumulator machine: sequencer, memories and result register.
`timescale 1ns / 1ps

// The core handles one request beat at a time and returns exactly one result beat
// for each. A step beat goes in order from acceptance to a result in the output
// register: the instruction memory is read at the program counter (opcode and operand
// on two read ports), then the data memory is read at the operand, then the
// instruction executes and writes back. A load beat puts the opcode and then the
// operand word into the single-write-port instruction memory, one after the other; a
// step while halted goes straight to a halt result. The next request is accepted in
// the cycle after a result is registered, while it may still be waiting on the sink.
// Data memory reads as zero after reset through one valid bit per word, so no clearing
// pass is needed; instruction words read before they are loaded return undefined data.
module tiny_accumulator_machine_core
    import tam_pkg::*;
#(
    parameter int INSTR_WORDS = 256,
    parameter int DATA_WORDS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tam_req_if.sink    i_req,
    tam_rsp_if.source  o_rsp
);

    localparam int IW  = $clog2(INSTR_WORDS);
    localparam int PW  = IW + 1;
    localparam int DAW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

    // Storage.
    logic [WORD_W-1:0] imem [INSTR_WORDS];
    logic [ACC_W-1:0]  dmem [DATA_WORDS];

    // Control and architectural state.
    t_state            r_state, n_state;
    logic [IW-1:0]     r_pc;
    logic [ACC_W-1:0]  r_acc;
    logic              r_halted;
    logic [DATA_WORDS-1:0] r_dvalid;

    // Per-item working registers.
    logic [IW-1:0]     r_ld_word;
    logic [WORD_W-1:0] r_ld_oper;
    logic [ACC_W-1:0]  r_in_value;
    logic [WORD_W-1:0] r_opc;
    logic [WORD_W-1:0] r_arg;
    logic [ACC_W-1:0]  r_dword;
    logic              r_dword_ok;

    // Output register.
    logic              r_ovalid;
    t_status           r_o_status;
    logic [PC_OUT_W-1:0] r_o_pc;
    logic [ACC_W-1:0]  r_o_acc;
    logic              r_o_outv;
    logic [WORD_W-1:0] r_o_opc;

    // Constant address tables: word address of a load slot and jump target per operand.
    logic [IW-1:0] slot_word [LOAD_SLOTS];
    logic [IW-1:0] arg_word  [ARG_VALUES];

    for (genvar g = 0; g < LOAD_SLOTS; g++) begin : g_slot
        assign slot_word[g] = IW'((2 * g) % INSTR_WORDS);
    end
    for (genvar g = 0; g < ARG_VALUES; g++) begin : g_arg
        assign arg_word[g] = IW'(g % INSTR_WORDS);
    end

    // Control strobes.
    logic              accept;
    logic              slot_free;
    logic              commit;
    logic              imem_we;
    logic [IW-1:0]     imem_waddr;
    logic [WORD_W-1:0] imem_wdata;
    logic              imem_re;
    logic              dmem_re;
    logic              dmem_we;

    // Address arithmetic.
    logic [IW-1:0] pc_inc1;
    logic [IW-1:0] ld_inc1;
    logic [PW-1:0] pc_sum2;
    logic [IW-1:0] pc_step;
    logic [PW-1:0] skip_sum2;
    logic [IW-1:0] pc_skip;

    // Execute results.
    logic [ACC_W-1:0]  data_val;
    logic              needs_data;
    logic              fault;
    logic [ACC_W-1:0]  x_acc;
    logic [IW-1:0]     x_pc;
    logic              x_halt;
    t_status           x_status;
    logic              x_outv;

    // Result beat contents.
    t_status             res_status;
    logic [PC_OUT_W-1:0] res_pc;
    logic [ACC_W-1:0]    res_acc;
    logic                res_outv;
    logic [WORD_W-1:0]   res_opc;

    assign slot_free = !r_ovalid || o_rsp.ready;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    if (!i_req.req_type) begin
                        n_state = S_LOAD;
                    end else if (r_halted) begin
                        n_state = S_HALT;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: n_state = S_EXEC;
            S_LOAD, S_EXEC, S_HALT: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State machine outputs.
    always_comb begin
        i_req.ready = 1'b0;
        accept      = 1'b0;
        commit      = 1'b0;
        imem_we     = 1'b0;
        imem_waddr  = ld_inc1;
        imem_wdata  = r_ld_oper;
        imem_re     = 1'b0;
        dmem_re     = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                accept      = i_req.valid;
                if (i_req.valid && !i_req.req_type) begin
                    // Opcode word goes in now, the operand word in the next cycle.
                    imem_we    = 1'b1;
                    imem_waddr = slot_word[i_req.load_index];
                    imem_wdata = i_req.opcode_word;
                end
                imem_re = i_req.valid && i_req.req_type && !r_halted;
            end
            S_LOAD: begin
                imem_we = 1'b1;
                commit  = slot_free;
            end
            S_FETCH: dmem_re = 1'b1;
            S_EXEC:  commit  = slot_free;
            S_HALT:  commit  = slot_free;
            default: commit  = 1'b0;
        endcase
    end

    assign dmem_we = (r_state == S_EXEC) && commit && (r_opc == OP_STORE) && !fault;

    // Program counter wrap logic; INSTR_WORDS need not be a power of two.
    assign pc_inc1   = (r_pc == IW'(INSTR_WORDS - 1)) ? '0 : r_pc + 1'b1;
    assign ld_inc1   = (r_ld_word == IW'(INSTR_WORDS - 1)) ? '0 : r_ld_word + 1'b1;
    assign pc_sum2   = {1'b0, r_pc} + PW'(2);
    assign pc_step   = (pc_sum2 >= PW'(INSTR_WORDS)) ? IW'(pc_sum2 - PW'(INSTR_WORDS))
                                                     : IW'(pc_sum2);
    assign skip_sum2 = {1'b0, pc_step} + PW'(2);
    assign pc_skip   = (skip_sum2 >= PW'(INSTR_WORDS)) ? IW'(skip_sum2 - PW'(INSTR_WORDS))
                                                       : IW'(skip_sum2);

    // Execute stage.
    always_comb begin
        data_val   = r_dword_ok ? r_dword : '0;
        needs_data = (r_opc == OP_LOAD) || (r_opc == OP_ADD) ||
                     (r_opc == OP_STORE) || (r_opc == OP_SUB);
        fault      = needs_data && ({1'b0, r_arg} >= 9'(DATA_WORDS));
        x_acc      = r_acc;
        x_pc       = pc_step;
        x_halt     = r_halted;
        x_status   = ST_OK;
        x_outv     = 1'b0;
        if (fault) begin
            x_status = ST_FAULT;
        end else begin
            case (r_opc)
                OP_LOAD:  x_acc = data_val;
                OP_ADD:   x_acc = r_acc + data_val;
                OP_SUB:   x_acc = r_acc - data_val;
                OP_IN:    x_acc = r_in_value;
                OP_OUT:   x_outv = 1'b1;
                OP_END: begin
                    x_halt   = 1'b1;
                    x_status = ST_HALT;
                end
                OP_JMP:   x_pc = arg_word[r_arg];
                OP_SKIPZ: begin
                    if (r_acc == '0) begin
                        x_pc = pc_skip;
                    end
                end
                default:  x_acc = r_acc;
            endcase
        end
    end

    // Result selection.
    always_comb begin
        res_status = ST_LOADED;
        res_pc     = PC_OUT_W'(r_pc);
        res_acc    = r_acc;
        res_outv   = 1'b0;
        res_opc    = '0;
        case (r_state)
            S_EXEC: begin
                res_status = x_status;
                res_pc     = PC_OUT_W'(x_pc);
                res_acc    = x_acc;
                res_outv   = x_outv;
                res_opc    = r_opc;
            end
            S_HALT:  res_status = ST_HALT;
            default: res_status = ST_LOADED;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_acc    <= '0;
            r_halted <= 1'b0;
            r_dvalid <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit && (r_state == S_EXEC)) begin
                r_pc     <= x_pc;
                r_acc    <= x_acc;
                r_halted <= x_halt;
            end
            if (dmem_we) begin
                r_dvalid[r_arg[DAW-1:0]] <= 1'b1;
            end
            if (commit) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Item capture and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ld_word  <= slot_word[i_req.load_index];
            r_ld_oper  <= i_req.operand_word;
            r_in_value <= i_req.in_value;
        end
        if (commit) begin
            r_o_status <= res_status;
            r_o_pc     <= res_pc;
            r_o_acc    <= res_acc;
            r_o_outv   <= res_outv;
            r_o_opc    <= res_opc;
        end
    end

    // Instruction memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (imem_we) begin
            imem[imem_waddr] <= imem_wdata;
        end
        if (imem_re) begin
            r_opc <= imem[r_pc];
            r_arg <= imem[pc_inc1];
        end
    end

    // Data memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (dmem_we) begin
            dmem[r_arg[DAW-1:0]] <= r_acc;
        end
        if (dmem_re) begin
            r_dword    <= dmem[r_arg[DAW-1:0]];
            r_dword_ok <= r_dvalid[r_arg[DAW-1:0]];
        end
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.pc          = r_o_pc;
    assign o_rsp.acc         = r_o_acc;
    assign o_rsp.out_valid   = r_o_outv;
    assign o_rsp.exec_opcode = r_o_opc;

    // A new result only ever appears out of a state that produces one.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_LOAD || $past(r_state) == S_EXEC ||
                             $past(r_state) == S_HALT))
        else $error("result beat raised outside a result state");

    // The program counter stays within instruction memory.
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pc} < PW'(INSTR_WORDS))
        else $error("program counter beyond instruction memory");

    // While halted the program counter does not move.
    a_halt_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_halted) && r_halted) |-> (r_pc == $past(r_pc)))
        else $error("program counter moved while halted");

    // A fault is only reported for an opcode that addresses data memory.
    a_fault_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_status == ST_FAULT) |->
            (r_o_opc == OP_LOAD || r_o_opc == OP_ADD ||
             r_o_opc == OP_STORE || r_o_opc == OP_SUB))
        else $error("fault reported for an opcode without a data access");

endmodule
